@@ design/atdr_pkg.sv @@
// ============================================================================
// Alarm table package
// Shared constants, status codes, payload types and the control interface
// between the alarm table controller and datapath.
// ============================================================================
package atdr_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [31:0] PERIOD_RESET = 32'd86400;
  localparam logic [31:0] TIME_MAX     = 32'hFFFF_FFFF;

  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [2:0] ST_CREATED  = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_DELETED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_FIRED    = 3'd5;
  localparam logic [2:0] ST_NONE     = 3'd6;

  typedef struct packed {
    logic        func;
    logic [63:0] alarm_id;
    logic [31:0] set_time;
    logic        repeat_daily;
    logic [31:0] now_time;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] fired_id;
    logic [4:0]  entries_in_use;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [31:0]         due;
    logic                repeats;
  } entry_t;

  typedef struct packed {
    logic start;
    logic rd;
    logic ev;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic stall;
    logic scan_end;
    logic slot_free;
  } sts_t;

endpackage

@@ design/alarm_table_with_daily_repeat_core.sv @@
// ============================================================================
// Alarm table with daily repeat
// Compacted table of alarms with set, delete and tick handling.
// ============================================================================
// Request beats arrive on req_valid/req_ready and carry a set or a tick.
// Each request yields one or more response beats on rsp_valid/rsp_ready;
// the final beat of a request has last set. A set answers with one beat.
// A tick answers with one beat per fired alarm, or one "none due" beat.
// One request is handled at a time. For each valid entry the entry memory
// is read in one step and the entry evaluated in the next; a final step
// then closes the request. The final beat enters the output register at
// the same edge at which the block becomes ready again.
// A stalled receiver holds the scan when a further alarm fires, and holds
// the final step until the output register is free.
// The user must write the repeat period through cfg_wen/cfg_wdata only while
// idle; the block does not enforce this. Synchronous reset empties the
// table, restores the period to 86400 and drops any pending response beat.
// ============================================================================
module alarm_table_with_daily_repeat_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  atdr_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output atdr_pkg::rsp_t rsp,
  input  logic           cfg_wen,
  input  logic [31:0]    cfg_wdata
);
  import atdr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  atdr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  atdr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule

@@ design/atdr_ctrl.sv @@
// ============================================================================
// Alarm table controller
// Sequences one item at a time: a read and an evaluate step per table entry,
// then a final step that delivers the closing result beat.
// ============================================================================
module atdr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  atdr_pkg::sts_t sts,
  output atdr_pkg::cmd_t cmd
);
  import atdr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EV   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = sts.count_zero ? S_FIN : S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_EV;
      end
      S_EV: begin
        if (!sts.stall) begin
          cmd.ev     = 1'b1;
          state_next = sts.scan_end ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        if (sts.slot_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/atdr_dp.sv @@
// ============================================================================
// Alarm table datapath
// Entry memory, compacting scan pointers, held fired result, output register
// and the repeat period register.
// ============================================================================
module atdr_dp (
  input  logic           clk,
  input  logic           rst,
  input  atdr_pkg::req_t req,
  input  logic           cfg_wen,
  input  logic [31:0]    cfg_wdata,
  input  atdr_pkg::cmd_t cmd,
  output atdr_pkg::sts_t sts,
  output atdr_pkg::rsp_t rsp,
  output logic           rsp_valid,
  input  logic           rsp_ready
);
  import atdr_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata;

  req_t             item;
  logic [31:0]      period;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n_scan;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] wr_ptr;
  logic             hit;
  logic             pend_valid;
  logic [63:0]      pend_id;
  logic [CNT_W-1:0] pend_cnt;

  logic [KEY_BITS-1:0] key_in;
  logic                is_tick;
  logic                due;
  logic                match;
  logic                drop;
  logic                fire;
  logic [32:0]         sum;
  logic [31:0]         due_sat;
  entry_t              ev_entry;
  logic                slot_free;
  logic                create;
  rsp_t                fin_rsp;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;

  assign key_in    = item.alarm_id[KEY_BITS-1:0];
  assign is_tick   = (item.func == FUNC_TICK);
  assign due       = (item.now_time >= rdata.due);
  assign match     = (rdata.key == key_in);
  assign fire      = is_tick && due;
  assign sum       = {1'b0, rdata.due} + {1'b0, period};
  assign due_sat   = sum[32] ? TIME_MAX : sum[31:0];
  assign slot_free = !rsp_valid || rsp_ready;

  always_comb begin
    ev_entry = rdata;
    if (is_tick) begin
      drop = due && !rdata.repeats;
      if (due) begin
        ev_entry.due = due_sat;
      end
    end else begin
      drop = match && (item.set_time == 32'd0);
      if (match) begin
        ev_entry.due     = item.set_time;
        ev_entry.repeats = item.repeat_daily;
      end
    end
  end

  assign sts.count_zero = (count == '0);
  assign sts.stall      = fire && pend_valid && !slot_free;
  assign sts.scan_end   = ((rd_ptr + 1'b1) == n_scan);
  assign sts.slot_free  = slot_free;

  always_comb begin
    create  = 1'b0;
    fin_rsp = '0;
    fin_rsp.last           = 1'b1;
    fin_rsp.entries_in_use = 5'(count);
    if (is_tick) begin
      if (pend_valid) begin
        fin_rsp.status         = ST_FIRED;
        fin_rsp.fired_id       = pend_id;
        fin_rsp.entries_in_use = 5'(pend_cnt);
      end else begin
        fin_rsp.status = ST_NONE;
      end
    end else if (hit) begin
      fin_rsp.status = (item.set_time != 32'd0) ? ST_UPDATED : ST_DELETED;
    end else if (item.set_time != 32'd0) begin
      if (count < CNT_W'(TABLE_DEPTH)) begin
        create                 = 1'b1;
        fin_rsp.status         = ST_CREATED;
        fin_rsp.entries_in_use = 5'(count + 1'b1);
      end else begin
        fin_rsp.status = ST_FULL;
      end
    end else begin
      fin_rsp.status = ST_NOTFOUND;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr[IDX_W-1:0];
    mem_wdata = ev_entry;
    if (cmd.ev && !drop) begin
      mem_we = 1'b1;
    end else if (cmd.fin && create) begin
      mem_we            = 1'b1;
      mem_waddr         = count[IDX_W-1:0];
      mem_wdata.key     = key_in;
      mem_wdata.due     = item.set_time;
      mem_wdata.repeats = item.repeat_daily;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[rd_ptr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item   <= req;
      n_scan <= count;
      rd_ptr <= '0;
      wr_ptr <= '0;
      hit    <= 1'b0;
    end
    if (cmd.ev) begin
      rd_ptr <= rd_ptr + 1'b1;
      if (!drop) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (!is_tick && match) begin
        hit <= 1'b1;
      end
      if (fire) begin
        pend_id  <= 64'(rdata.key);
        pend_cnt <= drop ? count - 1'b1 : count;
      end
    end
    if (cmd.ev && fire && pend_valid) begin
      rsp.status         <= ST_FIRED;
      rsp.fired_id       <= pend_id;
      rsp.entries_in_use <= 5'(pend_cnt);
      rsp.last           <= 1'b0;
    end else if (cmd.fin) begin
      rsp <= fin_rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      period     <= PERIOD_RESET;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        period <= cfg_wdata;
      end
      if (cmd.ev && drop) begin
        count <= count - 1'b1;
      end else if (cmd.fin && create) begin
        count <= count + 1'b1;
      end
      if (cmd.start) begin
        pend_valid <= 1'b0;
      end else if (cmd.ev && fire) begin
        pend_valid <= 1'b1;
      end
      if ((cmd.ev && fire && pend_valid) || cmd.fin) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
